>>> hdl/kvl_pkg.sv
// Package for the keyframe vec3 interpolator: sizes, memory entry layout and
// the sequencer state type. Depends on nothing; used by kvl_div and keyframe_vec3_lerp.
package kvl_pkg;

    localparam int MAX_KEYS_DEF = 32;

    localparam int WORD_W   = 32;
    localparam int FRAC_W   = 16;
    localparam int COUNT_W  = 6;
    localparam int SLOT_W   = 5;
    localparam int AXES     = 3;

    // One memory entry: time, x, y, z from the lowest bit up.
    localparam int ENTRY_W  = 4 * WORD_W;
    localparam int TIME_LSB = 0;
    localparam int X_LSB    = WORD_W;
    localparam int Y_LSB    = 2 * WORD_W;
    localparam int Z_LSB    = 3 * WORD_W;

    localparam int S_TDATA_W = 168;
    localparam int M_TDATA_W = 104;

    localparam logic ACT_WRITE  = 1'b0;
    localparam logic ACT_SAMPLE = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_CHECK,
        ST_LAUNCH,
        ST_DIV,
        ST_MUL,
        ST_ADD,
        ST_FINISH
    } kvl_state_t;

endpackage

>>> hdl/kvl_ram.sv
// Generic single-port-write, single-port-read RAM with a registered read.
// Depends on nothing.
module kvl_ram #(
    parameter int WIDTH = 128,
    parameter int DEPTH = 32,
    parameter int AW    = $clog2(DEPTH)
) (
    input  logic             aclk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

>>> hdl/kvl_div.sv
// Restoring divider giving a Q0.16 fraction num / den for num < den, one
// quotient bit per cycle. Depends on kvl_pkg.
module kvl_div (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       start,
    input  logic [kvl_pkg::WORD_W-1:0] num,
    input  logic [kvl_pkg::WORD_W-1:0] den,
    output logic                       done,
    output logic [kvl_pkg::FRAC_W-1:0] quot
);

    localparam int CW = $clog2(kvl_pkg::FRAC_W);

    logic [kvl_pkg::WORD_W-1:0] rem_reg;
    logic [kvl_pkg::WORD_W-1:0] den_reg;
    logic [kvl_pkg::FRAC_W-1:0] quot_reg;
    logic [CW-1:0]              cnt_reg;
    logic                       busy_reg;
    logic                       done_reg;

    logic [kvl_pkg::WORD_W:0]   shifted;
    logic [kvl_pkg::WORD_W:0]   trial;
    logic                       fits;

    assign shifted = {rem_reg, 1'b0};
    assign trial   = shifted - {1'b0, den_reg};
    assign fits    = (shifted >= {1'b0, den_reg});

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == CW'(kvl_pkg::FRAC_W - 1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            rem_reg <= num;
            den_reg <= den;
        end else if (busy_reg) begin
            rem_reg  <= fits ? trial[kvl_pkg::WORD_W-1:0] : shifted[kvl_pkg::WORD_W-1:0];
            quot_reg <= {quot_reg[kvl_pkg::FRAC_W-2:0], fits};
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

>>> hdl/keyframe_vec3_lerp.sv
// Keyframe table with linear interpolation of a signed Q16.16 vec3.
// A keyframe write beat is accepted while the sequencer is idle. A sample runs a
// read state and a check state for each key examined by the linear search over
// the single-port key memory, then the serial Q0.16 divider, a multiply state and
// an add state per axis on the shared multiplier over three axes, and a finish
// state that loads the output; no new beat is taken before then. The search covers
// at most key_count keys, held to 1..MAX_KEYS; a result held by m_tready stalls the next beat. Reset clears
// the sequencer and output valid and sets key_count to 1.
module keyframe_vec3_lerp #(
    parameter int MAX_KEYS = kvl_pkg::MAX_KEYS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [kvl_pkg::COUNT_W-1:0]   cfg_wr_data,  // key_count
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // key_index, key_time, key_x, key_y, key_z, sample_time, zero padding
    input  logic [kvl_pkg::S_TDATA_W-1:0] s_tdata,
    input  logic                          s_tuser,      // action
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // out_x, out_y, out_z, segment, zero padding
    output logic [kvl_pkg::M_TDATA_W-1:0] m_tdata
);

    localparam int AW = $clog2(MAX_KEYS);
    localparam int W  = kvl_pkg::WORD_W;
    localparam int PW = W + 1 + kvl_pkg::FRAC_W + 1;

    kvl_pkg::kvl_state_t state_reg, state_next;

    logic [kvl_pkg::COUNT_W-1:0] key_count_reg;
    logic [AW-1:0]               last_reg;
    logic [AW-1:0]               idx_reg;
    logic [AW-1:0]               seg_reg;
    logic [W-1:0]                t_reg;
    logic [W-1:0]                prev_time_reg;
    logic [W-1:0]                start_reg [kvl_pkg::AXES];
    logic signed [W:0]           diff_reg  [kvl_pkg::AXES];
    logic [W-1:0]                res_reg   [kvl_pkg::AXES];
    logic [W-1:0]                num_reg;
    logic [W-1:0]                den_reg;
    logic [kvl_pkg::FRAC_W-1:0]  factor_reg;
    logic signed [PW-1:0]        prod_reg;
    logic [1:0]                  ax_reg;
    logic                        m_valid_reg;
    logic [kvl_pkg::M_TDATA_W-1:0] m_data_reg;

    logic [kvl_pkg::SLOT_W-1:0]  in_slot;
    logic [W-1:0]                in_sample;
    logic [31:0]                 slot_ext;
    logic                        slot_ok;
    logic [31:0]                 last_w;
    logic                        ram_wr_en;
    logic                        ram_rd_en;
    logic [kvl_pkg::ENTRY_W-1:0] rd_data;
    logic [W-1:0]                rd_time;
    logic [W-1:0]                rd_axis [kvl_pkg::AXES];
    logic                        t_lt;
    logic                        chk_emit;
    logic                        chk_found;
    logic                        div_start;
    logic                        div_done;
    logic [kvl_pkg::FRAC_W-1:0]  div_quot;
    logic                        out_free;
    logic [31:0]                 seg_ext;

    assign in_slot   = s_tdata[kvl_pkg::SLOT_W-1:0];
    assign in_sample = s_tdata[kvl_pkg::SLOT_W+5*W-1 -: W];
    assign slot_ext  = 32'(in_slot);
    assign slot_ok   = (slot_ext < 32'(MAX_KEYS));

    always_comb begin
        if (key_count_reg == '0) begin
            last_w = '0;
        end else if (32'(key_count_reg) > 32'(MAX_KEYS)) begin
            last_w = 32'(MAX_KEYS - 1);
        end else begin
            last_w = 32'(key_count_reg) - 32'd1;
        end
    end

    kvl_ram #(
        .WIDTH (kvl_pkg::ENTRY_W),
        .DEPTH (MAX_KEYS),
        .AW    (AW)
    ) u_ram (
        .aclk    (aclk),
        .wr_en   (ram_wr_en),
        .wr_addr (slot_ext[AW-1:0]),
        .wr_data (s_tdata[kvl_pkg::SLOT_W +: kvl_pkg::ENTRY_W]),
        .rd_en   (ram_rd_en),
        .rd_addr (idx_reg),
        .rd_data (rd_data)
    );

    kvl_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (num_reg),
        .den     (den_reg),
        .done    (div_done),
        .quot    (div_quot)
    );

    assign rd_time    = rd_data[kvl_pkg::TIME_LSB +: W];
    assign rd_axis[0] = rd_data[kvl_pkg::X_LSB +: W];
    assign rd_axis[1] = rd_data[kvl_pkg::Y_LSB +: W];
    assign rd_axis[2] = rd_data[kvl_pkg::Z_LSB +: W];

    assign t_lt      = (t_reg < rd_time);
    assign chk_emit  = (idx_reg == '0) ? ((last_reg == '0) || t_lt)
                                       : (!t_lt && (idx_reg == last_reg));
    assign chk_found = (idx_reg != '0) && t_lt;
    assign out_free  = !m_valid_reg || m_tready;

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            kvl_pkg::ST_IDLE: begin
                if (s_tvalid && s_tuser == kvl_pkg::ACT_SAMPLE) begin
                    state_next = kvl_pkg::ST_READ;
                end
            end
            kvl_pkg::ST_READ:   state_next = kvl_pkg::ST_CHECK;
            kvl_pkg::ST_CHECK: begin
                if (chk_emit) begin
                    state_next = kvl_pkg::ST_FINISH;
                end else if (chk_found) begin
                    state_next = kvl_pkg::ST_LAUNCH;
                end else begin
                    state_next = kvl_pkg::ST_READ;
                end
            end
            kvl_pkg::ST_LAUNCH: state_next = kvl_pkg::ST_DIV;
            kvl_pkg::ST_DIV: begin
                if (div_done) begin
                    state_next = kvl_pkg::ST_MUL;
                end
            end
            kvl_pkg::ST_MUL:    state_next = kvl_pkg::ST_ADD;
            kvl_pkg::ST_ADD: begin
                state_next = (ax_reg == 2'(kvl_pkg::AXES - 1)) ? kvl_pkg::ST_FINISH
                                                                : kvl_pkg::ST_MUL;
            end
            kvl_pkg::ST_FINISH: begin
                if (out_free) begin
                    state_next = kvl_pkg::ST_IDLE;
                end
            end
            default:            state_next = kvl_pkg::ST_IDLE;
        endcase
    end

    always_comb begin
        s_tready  = (state_reg == kvl_pkg::ST_IDLE);
        ram_wr_en = (state_reg == kvl_pkg::ST_IDLE) && s_tvalid
                    && (s_tuser == kvl_pkg::ACT_WRITE) && slot_ok;
        ram_rd_en = (state_reg == kvl_pkg::ST_READ);
        div_start = (state_reg == kvl_pkg::ST_LAUNCH);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= kvl_pkg::ST_IDLE;
            key_count_reg <= kvl_pkg::COUNT_W'(1);
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg <= state_next;
            if (cfg_wr_en) begin
                key_count_reg <= cfg_wr_data;
            end
            if (state_reg == kvl_pkg::ST_FINISH && out_free) begin
                m_valid_reg <= 1'b1;
            end else if (m_tready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        case (state_reg)
            kvl_pkg::ST_IDLE: begin
                t_reg    <= in_sample;
                last_reg <= last_w[AW-1:0];
                idx_reg  <= '0;
            end
            kvl_pkg::ST_CHECK: begin
                seg_reg <= (idx_reg == '0) ? '0 : idx_reg - 1'b1;
                if (chk_emit) begin
                    for (int a = 0; a < kvl_pkg::AXES; a++) begin
                        res_reg[a] <= rd_axis[a];
                    end
                end else if (chk_found) begin
                    num_reg <= t_reg - prev_time_reg;
                    den_reg <= rd_time - prev_time_reg;
                    for (int a = 0; a < kvl_pkg::AXES; a++) begin
                        diff_reg[a] <= $signed({rd_axis[a][W-1], rd_axis[a]})
                                     - $signed({start_reg[a][W-1], start_reg[a]});
                    end
                end else begin
                    prev_time_reg <= rd_time;
                    for (int a = 0; a < kvl_pkg::AXES; a++) begin
                        start_reg[a] <= rd_axis[a];
                    end
                    idx_reg <= idx_reg + 1'b1;
                end
            end
            kvl_pkg::ST_DIV: begin
                factor_reg <= div_quot;
                ax_reg     <= '0;
            end
            kvl_pkg::ST_MUL: begin
                prod_reg <= PW'(diff_reg[ax_reg]) * PW'($signed({1'b0, factor_reg}));
            end
            kvl_pkg::ST_ADD: begin
                res_reg[ax_reg] <= start_reg[ax_reg] + prod_reg[kvl_pkg::FRAC_W +: W];
                ax_reg          <= ax_reg + 1'b1;
            end
            kvl_pkg::ST_FINISH: begin
                if (out_free) begin
                    m_data_reg <= {3'b000, seg_ext[kvl_pkg::SLOT_W-1:0],
                                   res_reg[2], res_reg[1], res_reg[0]};
                end
            end
            default: begin
            end
        endcase
    end

    assign seg_ext  = 32'(seg_reg);
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule
